// ===== src/ltc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_pkg
// shared constants and types of the lru tag cache lookup unit
// ----------------------------------------------------------------------------
package ltc_pkg;

    // default geometry
    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int STAMP_BITS_DEF = 30;

    // fixed result field widths
    localparam int SLOT_W  = 4;
    localparam int EVKEY_W = 32;

    // lookup sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

endpackage : ltc_pkg
`default_nettype wire

// ===== src/ltc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module ltc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : ltc_ram
`default_nettype wire

// ===== src/lru_tag_cache_lookup_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_tag_cache_lookup_unit
// fully associative cache directory with timestamp lru replacement
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A lookup walks the
// directory one entry per cycle through a single ram read port and one shared
// key/stamp compare unit, stops early on a hit, then writes the chosen entry
// back in a write-back state. The directory ram has a registered read port
// that feeds the compare unit. A flush does not raise busy. The result
// appears on the o_ result ports for exactly one cycle with o_strobe high,
// in the cycle after the last busy cycle (the cycle after the accepting edge
// for a flush). The receiver cannot stall: the result must be captured in
// that cycle. A new word may be started in the same cycle that a result is
// strobed. Valid bits live in flip-flops, so reset and flush clear the
// directory at once with no clearing pass.
// ----------------------------------------------------------------------------
module lru_tag_cache_lookup_unit
    import ltc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // command side
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_action,
    input  wire logic [KEY_BITS-1:0] i_lookup_key,
    // result side
    output logic                     o_strobe,
    output logic                     o_hit,
    output logic [SLOT_W-1:0]        o_slot,
    output logic                     o_evicted,
    output logic [EVKEY_W-1:0]       o_evicted_key
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int DATA_W = KEY_BITS + STAMP_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // sequencer
    t_state r_state, n_state;

    // directory control state
    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [STAMP_BITS-1:0] r_use_cnt, n_use_cnt;

    // scan bookkeeping
    logic [KEY_BITS-1:0]   r_key, n_key;           // key under lookup
    logic [IDX_W-1:0]      r_idx, n_idx;           // ram read address
    logic                  r_issue_done, n_issue_done;
    logic                  r_cmp_vld, n_cmp_vld;   // ram data belongs to r_cmp_idx
    logic [IDX_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                  r_hit, n_hit;
    logic [IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic                  r_vac_found, n_vac_found;
    logic [IDX_W-1:0]      r_vac_idx, n_vac_idx;
    logic [STAMP_BITS-1:0] r_oldest, n_oldest;
    logic [IDX_W-1:0]      r_victim, n_victim;
    logic [KEY_BITS-1:0]   r_victim_key, n_victim_key;

    // result registers
    logic                  r_strobe, n_strobe;
    logic                  r_res_hit, n_res_hit;
    logic [SLOT_W-1:0]     r_res_slot, n_res_slot;
    logic                  r_res_ev, n_res_ev;
    logic [EVKEY_W-1:0]    r_res_evkey, n_res_evkey;

    // ram interface
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [DATA_W-1:0]     ram_wdata;
    logic [DATA_W-1:0]     ram_rdata;
    logic [KEY_BITS-1:0]   rd_key;
    logic [STAMP_BITS-1:0] rd_stamp;

    // control decodes
    logic                  accept;
    logic                  issue;
    logic                  cmp_entry_valid;
    logic                  key_eq;
    logic                  stamp_lt;
    logic                  scan_hit;
    logic                  scan_end;

    // write-back choice
    logic [IDX_W-1:0]      wb_slot;
    logic                  wb_evict;
    logic [IDX_W+SLOT_W-1:0]    slot_ext;
    logic [KEY_BITS+EVKEY_W-1:0] evkey_ext;

    // key and stamp of every entry share one ram word
    ltc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_stamp = ram_rdata[STAMP_BITS-1:0];
    assign rd_key   = ram_rdata[STAMP_BITS +: KEY_BITS];

    // shared compare unit, fed with the entry read last cycle
    assign cmp_entry_valid = r_valid[r_cmp_idx];
    assign key_eq          = (rd_key == r_key);
    assign stamp_lt        = (rd_stamp < r_oldest);
    assign scan_hit        = r_cmp_vld && cmp_entry_valid && key_eq;
    assign scan_end        = r_cmp_vld && (scan_hit || (r_cmp_idx == LAST_IDX));

    // hit wins, then lowest vacant entry, then the lru victim
    always_comb begin
        priority if (r_hit) begin
            wb_slot = r_hit_idx;
        end else if (r_vac_found) begin
            wb_slot = r_vac_idx;
        end else begin
            wb_slot = r_victim;
        end
    end
    assign wb_evict  = !r_hit && !r_vac_found;
    assign slot_ext  = {{SLOT_W{1'b0}}, wb_slot};
    assign evkey_ext = {{EVKEY_W{1'b0}}, r_victim_key};

    assign accept = start && !busy;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !i_action) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state decoded outputs
    always_comb begin
        busy      = 1'b1;
        issue     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = wb_slot;
        ram_wdata = {r_key, r_use_cnt};
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_SCAN: begin
                issue = !r_issue_done && !scan_end;
            end
            ST_WRITE: begin
                ram_we = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_valid      = r_valid;
        n_use_cnt    = r_use_cnt;
        n_key        = r_key;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_cmp_vld    = issue;
        n_cmp_idx    = r_idx;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_vac_found  = r_vac_found;
        n_vac_idx    = r_vac_idx;
        n_oldest     = r_oldest;
        n_victim     = r_victim;
        n_victim_key = r_victim_key;
        n_strobe     = 1'b0;
        n_res_hit    = r_res_hit;
        n_res_slot   = r_res_slot;
        n_res_ev     = r_res_ev;
        n_res_evkey  = r_res_evkey;

        // start of a word
        if (accept) begin
            if (i_action) begin
                // flush: empty directory, zero result next cycle
                n_valid     = '0;
                n_use_cnt   = '0;
                n_strobe    = 1'b1;
                n_res_hit   = 1'b0;
                n_res_slot  = '0;
                n_res_ev    = 1'b0;
                n_res_evkey = '0;
            end else begin
                n_key        = i_lookup_key;
                n_idx        = '0;
                n_issue_done = 1'b0;
                n_hit        = 1'b0;
                n_hit_idx    = '0;
                n_vac_found  = 1'b0;
                n_vac_idx    = '0;
                n_oldest     = '1;
                n_victim     = '0;
                n_victim_key = '0;
            end
        end

        // step the read address through the directory
        if (issue) begin
            if (r_idx == LAST_IDX) begin
                n_issue_done = 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end

        // examine the entry read last cycle
        if (r_cmp_vld) begin
            priority if (!cmp_entry_valid) begin
                if (!r_vac_found) begin
                    n_vac_found = 1'b1;
                    n_vac_idx   = r_cmp_idx;
                end
            end else if (key_eq) begin
                n_hit     = 1'b1;
                n_hit_idx = r_cmp_idx;
            end else begin
                // entry 0 is the fallback victim, so keep its key
                if (r_cmp_idx == '0) begin
                    n_victim_key = rd_key;
                end
                if (stamp_lt) begin
                    n_oldest     = rd_stamp;
                    n_victim     = r_cmp_idx;
                    n_victim_key = rd_key;
                end
            end
        end

        // write back the chosen entry and post the result
        if (r_state == ST_WRITE) begin
            n_valid[wb_slot] = 1'b1;
            n_use_cnt        = r_use_cnt + 1'b1;
            n_strobe         = 1'b1;
            n_res_hit        = r_hit;
            n_res_slot       = slot_ext[SLOT_W-1:0];
            n_res_ev         = wb_evict;
            n_res_evkey      = wb_evict ? evkey_ext[EVKEY_W-1:0] : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_use_cnt    <= '0;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_use_cnt    <= n_use_cnt;
            r_issue_done <= n_issue_done;
            r_cmp_vld    <= n_cmp_vld;
            r_strobe     <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_vac_found  <= n_vac_found;
        r_vac_idx    <= n_vac_idx;
        r_oldest     <= n_oldest;
        r_victim     <= n_victim;
        r_victim_key <= n_victim_key;
        r_res_hit    <= n_res_hit;
        r_res_slot   <= n_res_slot;
        r_res_ev     <= n_res_ev;
        r_res_evkey  <= n_res_evkey;
    end

    assign o_strobe      = r_strobe;
    assign o_hit         = r_res_hit;
    assign o_slot        = r_res_slot;
    assign o_evicted     = r_res_ev;
    assign o_evicted_key = r_res_evkey;

endmodule : lru_tag_cache_lookup_unit
`default_nettype wire
